>>> design/dnsc_pkg.sv
// Shared types and constants for the domain-name checker and encoder.
// No dependencies; every other file imports this package.
package dnsc_pkg;

    localparam int CHAR_W    = 8;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int NAME_W    = 6;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAST_LABEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAST_LABEL  = 2'd2;

    localparam logic [CFG_W-1:0] MAX_NAME_LENGTH_RST = 6'd63;
    localparam logic [CFG_W-1:0] MIN_LAST_LABEL_RST  = 6'd2;
    localparam logic [CFG_W-1:0] MAX_LAST_LABEL_RST  = 6'd6;

    // Keeps length byte, label, terminator and status within 63 results
    localparam logic [7:0] LONGEST_FINAL_LABEL = 8'd60;

    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_LEN,
        S_RD,
        S_CHR,
        S_TERM,
        S_STATUS
    } t_state;

    typedef enum logic [1:0] {
        SEL_LEN,
        SEL_CHR,
        SEL_TERM,
        SEL_STATUS
    } t_sel;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic idx_inc;
        logic load;
        t_sel sel;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic do_label;
        logic do_term;
        logic do_status;
        logic len_zero;
        logic idx_last;
        logic out_free;
    } t_status;

endpackage

>>> design/dnsc_in_if.sv
// Character request channel: valid/ready handshake with one name character.
// Depends on dnsc_pkg for field widths.
interface dnsc_in_if import dnsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_name;

    modport source (output valid, output char_code, output end_of_name, input ready);
    modport sink   (input valid, input char_code, input end_of_name, output ready);
endinterface

>>> design/dnsc_out_if.sv
// Result request channel: encoded byte or end-of-name status.
// Depends on dnsc_pkg for field widths.
interface dnsc_out_if import dnsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] wire_byte;
    logic              is_status;
    logic              name_ok;
    logic              last_of_run;

    modport source (output valid, output wire_byte, output is_status, output name_ok,
                    output last_of_run, input ready);
    modport sink   (input valid, input wire_byte, input is_status, input name_ok,
                    input last_of_run, output ready);
endinterface

>>> design/dnsc_ctrl.sv
// Controller: sequences acceptance of a character and the result burst it causes.
// Depends on dnsc_pkg; drives the datapath through t_cmd, watches t_status.
module dnsc_ctrl import dnsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_st.do_label) begin
                    n_state = S_LEN;
                end else if (i_st.do_status) begin
                    n_state = S_STATUS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LEN: begin
                if (i_st.out_free) begin
                    if (!i_st.len_zero) begin
                        n_state = S_RD;
                    end else if (i_st.do_term) begin
                        n_state = S_TERM;
                    end else if (i_st.do_status) begin
                        n_state = S_STATUS;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHR;
            end
            S_CHR: begin
                if (i_st.out_free) begin
                    if (!i_st.idx_last) begin
                        n_state = S_RD;
                    end else if (i_st.do_term) begin
                        n_state = S_TERM;
                    end else if (i_st.do_status) begin
                        n_state = S_STATUS;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TERM: begin
                if (i_st.out_free) begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.rd_issue = 1'b0;
        o_cmd.idx_inc  = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.sel      = SEL_LEN;
        o_cmd.last     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_DISP: begin
            end
            S_LEN: begin
                o_cmd.load = i_st.out_free;
                o_cmd.sel  = SEL_LEN;
                o_cmd.last = i_st.len_zero && !i_st.do_term && !i_st.do_status;
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            S_CHR: begin
                o_cmd.load    = i_st.out_free;
                o_cmd.idx_inc = i_st.out_free;
                o_cmd.sel     = SEL_CHR;
                o_cmd.last    = i_st.idx_last && !i_st.do_term && !i_st.do_status;
            end
            S_TERM: begin
                o_cmd.load = i_st.out_free;
                o_cmd.sel  = SEL_TERM;
            end
            S_STATUS: begin
                o_cmd.load = i_st.out_free;
                o_cmd.sel  = SEL_STATUS;
                o_cmd.last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // The status result always closes the run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && o_cmd.sel == SEL_STATUS) |-> o_cmd.last)
        else $error("status result without last_of_run");

    // A character is only sent after its store read was issued
    a_chr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHR) |-> ($past(r_state) == S_RD || $past(r_state) == S_CHR))
        else $error("character sent without a store read");

endmodule

>>> design/dnsc_datapath.sv
// Datapath: case folding, name checks, counters, label store and result register.
// Depends on dnsc_pkg; commanded by dnsc_ctrl through t_cmd.
module dnsc_datapath import dnsc_pkg::*; #(
    parameter int LABEL_STORE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_st,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_end_of_name,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAR_W-1:0]    o_wire_byte,
    output logic                 o_is_status,
    output logic                 o_name_ok,
    output logic                 o_last_of_run
);

    localparam int LCW  = $clog2(LABEL_STORE_DEPTH + 1);
    localparam int IDXW = $clog2(LABEL_STORE_DEPTH);
    localparam logic [LCW-1:0] DEPTH_L = LCW'(LABEL_STORE_DEPTH);

    // Configuration
    logic [CFG_W-1:0] r_max_name;
    logic [CFG_W-1:0] r_min_last;
    logic [CFG_W-1:0] r_max_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name <= MAX_NAME_LENGTH_RST;
            r_min_last <= MIN_LAST_LABEL_RST;
            r_max_last <= MAX_LAST_LABEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_NAME_LENGTH: r_max_name <= i_cfg_data;
                CFG_MIN_LAST_LABEL:  r_min_last <= i_cfg_data;
                CFG_MAX_LAST_LABEL:  r_max_last <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Name state
    logic [NAME_W-1:0] r_name_count;
    logic [LCW-1:0]    r_label_count;
    logic              r_bad;

    // Burst descriptor latched at accept
    logic           r_do_label;
    logic           r_do_term;
    logic           r_do_status;
    logic           r_ok;
    logic [LCW-1:0] r_len;
    logic [IDXW-1:0] r_idx;

    logic [CHAR_W-1:0] r_rd_data;
    logic [CHAR_W-1:0] r_store [LABEL_STORE_DEPTH];

    // Per-character evaluation
    logic [CHAR_W-1:0] c_fold;
    logic              is_letter;
    logic              is_digit;
    logic              is_dot;
    logic              is_hyph;
    logic              too_long;
    logic              store_full;
    logic              store_we;
    logic              bad_next;
    logic [LCW-1:0]    lc_next;
    logic [CFG_W-1:0]  least;
    logic [7:0]        lc_ext;
    logic              ok_next;
    logic              dot_label;

    always_comb begin
        c_fold = i_char_code;
        if (i_char_code >= CHAR_UP_A && i_char_code <= CHAR_UP_Z) begin
            c_fold = i_char_code + CASE_OFFSET;
        end
        is_letter  = (c_fold >= CHAR_LOW_A) && (c_fold <= CHAR_LOW_Z);
        is_digit   = (c_fold >= CHAR_ZERO) && (c_fold <= CHAR_NINE);
        is_dot     = (c_fold == CHAR_DOT);
        is_hyph    = (c_fold == CHAR_HYPHEN);
        too_long   = (r_name_count >= r_max_name);
        store_full = (r_label_count >= DEPTH_L);

        bad_next = r_bad || (!is_letter && !is_digit && !is_dot && !is_hyph)
                   || (r_name_count == '0 && is_hyph) || too_long
                   || (!too_long && !is_dot && store_full);
        store_we  = !too_long && !is_dot && !store_full;
        dot_label = !too_long && is_dot && !i_end_of_name;

        lc_next = r_label_count;
        if (!too_long && is_dot) begin
            lc_next = '0;
        end else if (store_we) begin
            lc_next = r_label_count + 1'b1;
        end

        // Zero minimum acts as one
        least   = (r_min_last == '0) ? CFG_W'(1) : r_min_last;
        lc_ext  = 8'(lc_next);
        ok_next = !bad_next && !is_hyph && !is_dot
                  && (lc_ext >= 8'(least)) && (lc_ext <= 8'(r_max_last))
                  && (lc_ext <= LONGEST_FINAL_LABEL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_count  <= '0;
            r_label_count <= '0;
            r_bad         <= 1'b0;
            r_do_label    <= 1'b0;
            r_do_term     <= 1'b0;
            r_do_status   <= 1'b0;
            r_ok          <= 1'b0;
            r_len         <= '0;
            r_idx         <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_do_status <= i_end_of_name;
                r_do_term   <= i_end_of_name && ok_next;
                r_do_label  <= dot_label || (i_end_of_name && ok_next);
                r_ok        <= ok_next;
                r_len       <= dot_label ? r_label_count : lc_next;
                r_idx       <= '0;
                if (i_end_of_name) begin
                    r_name_count  <= '0;
                    r_label_count <= '0;
                    r_bad         <= 1'b0;
                end else begin
                    r_name_count  <= too_long ? r_name_count : r_name_count + 1'b1;
                    r_label_count <= lc_next;
                    r_bad         <= bad_next;
                end
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Label store: one write port at accept, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && store_we) begin
            r_store[r_label_count[IDXW-1:0]] <= c_fold;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_store[r_idx];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_last_of_run <= i_cmd.last;
            o_is_status   <= 1'b0;
            o_name_ok     <= 1'b0;
            unique case (i_cmd.sel)
                SEL_LEN:  o_wire_byte <= CHAR_W'(r_len);
                SEL_CHR:  o_wire_byte <= r_rd_data;
                SEL_TERM: o_wire_byte <= '0;
                SEL_STATUS: begin
                    o_wire_byte <= '0;
                    o_is_status <= 1'b1;
                    o_name_ok   <= r_ok;
                end
                default: o_wire_byte <= '0;
            endcase
        end
    end

    always_comb begin
        o_st.do_label  = r_do_label;
        o_st.do_term   = r_do_term;
        o_st.do_status = r_do_status;
        o_st.len_zero  = (r_len == '0);
        o_st.idx_last  = ((LCW'(r_idx) + 1'b1) == r_len);
        o_st.out_free  = !o_out_valid || i_out_ready;
    end

    // Name state is already cleared when the status goes out
    a_cleared_at_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.sel == SEL_STATUS)
        |-> (r_name_count == '0 && r_label_count == '0 && !r_bad))
        else $error("name state not cleared at status");

    // Reads stay inside the buffered label
    a_read_in_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (LCW'(r_idx) < r_len))
        else $error("label store read past label length");

    // Never more characters buffered than the store holds
    a_label_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_label_count <= DEPTH_L)
        else $error("label count beyond store depth");

endmodule

>>> design/dns_name_check_and_encode_top.sv
// Top level of the domain-name checker and encoder: channels, controller, datapath.
// Depends on dnsc_pkg, dnsc_in_if, dnsc_out_if, dnsc_ctrl and dnsc_datapath.
//
//   channel   direction  payload                                   handshake
//   i_char    in         char_code[7:0], end_of_name               valid/ready
//   o_byte    out        wire_byte[7:0], is_status, name_ok,       valid/ready
//                        last_of_run
//   cfg       in         i_cfg_idx[1:0], i_cfg_data[5:0]           i_cfg_we
//
// A character that causes no result passes through accept, then dispatch. A dot before
// the end adds a length result and a character result per label character; an end of a
// valid name adds those, a terminator and a status, of a bad name only the status. Each
// label character costs one label-store read and one result-register load.
// Reset (i_rst_n low at a clock edge) clears the name state and loads register defaults.
// A stalled o_byte holds the controller in its emit state; no character is taken
// until the whole burst has entered the result register.
module dns_name_check_and_encode_top import dnsc_pkg::*; #(
    parameter int LABEL_STORE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dnsc_in_if.sink              i_char,
    dnsc_out_if.source           o_byte,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    dnsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (i_char.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    dnsc_datapath #(
        .LABEL_STORE_DEPTH (LABEL_STORE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_char_code   (i_char.char_code),
        .i_end_of_name (i_char.end_of_name),
        .o_out_valid   (o_byte.valid),
        .i_out_ready   (o_byte.ready),
        .o_wire_byte   (o_byte.wire_byte),
        .o_is_status   (o_byte.is_status),
        .o_name_ok     (o_byte.name_ok),
        .o_last_of_run (o_byte.last_of_run)
    );

endmodule
